[rtl/pfc_pkg.sv]
// Shared types, register codes and constants of the pose fall classifier.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

    localparam int COORD_MAX_W = 16;
    localparam int JOINTS      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int ANG_STEPS   = 20;
    localparam int SCALE_SH    = 20;
    localparam int ZW          = 29;
    localparam int TAB_W       = 25;

    // keypoint numbers that are kept
    localparam int KP_L_SHOULDER = 5;
    localparam int KP_R_SHOULDER = 6;
    localparam int KP_L_HIP      = 11;
    localparam int KP_R_HIP      = 12;
    localparam int KP_L_KNEE     = 13;
    localparam int KP_R_KNEE     = 14;
    localparam int KP_L_ANKLE    = 15;
    localparam int KP_R_ANKLE    = 16;

    // slots of the joint store
    localparam int SL_SH0 = 0;
    localparam int SL_SH1 = 1;
    localparam int SL_HP0 = 2;
    localparam int SL_HP1 = 3;
    localparam int SL_KN0 = 4;
    localparam int SL_KN1 = 5;
    localparam int SL_AN0 = 6;
    localparam int SL_AN1 = 7;

    localparam logic [15:0] RST_CONF_THR  = 16'd32768;
    localparam logic [15:0] RST_ASPECT    = 16'd256;
    localparam logic [10:0] RST_KH_MIN    = 11'd450;
    localparam logic [10:0] RST_KH_MAX    = 11'd900;
    localparam logic [10:0] RST_TRUNK     = 11'd1200;
    localparam logic [10:0] RST_LEG       = 11'd1200;

    localparam logic signed [ZW-1:0] Z_ZERO = '0;
    localparam logic signed [ZW-1:0] Z_90   = ZW'(900 * 65536);
    localparam logic signed [ZW-1:0] Z_180  = ZW'(1800 * 65536);

    // atan(2^-i) in tenths of a degree, 16 fraction bits
    localparam logic [TAB_W-1:0] ATAN_TAB [ANG_STEPS] = '{
        25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451, 25'd2343786,
        25'd1173036,  25'd586661,   25'd293348,  25'd146676,  25'd73339,
        25'd36669,    25'd18335,    25'd9167,    25'd4584,    25'd2292,
        25'd1146,     25'd573,      25'd286,     25'd143,     25'd72
    };

    typedef enum logic [2:0] {
        CFG_CONF_THR = 3'd0,
        CFG_ASPECT   = 3'd1,
        CFG_KH_MIN   = 3'd2,
        CFG_KH_MAX   = 3'd3,
        CFG_TRUNK    = 3'd4,
        CFG_LEG      = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        RULE_NONE     = 3'd0,
        RULE_ANKLE    = 3'd1,
        RULE_KNEE     = 3'd2,
        RULE_ASPECT   = 3'd3,
        RULE_KNEE_HIP = 3'd4,
        RULE_TRUNK    = 3'd5
    } rule_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL_A,
        BK_MUL_B,
        BK_ANG_GO,
        BK_ANG_WAIT,
        BK_DECIDE
    } back_state_t;

    typedef struct packed {
        logic [15:0] conf_thr;
        logic [15:0] aspect_lim;
        logic [10:0] kh_min;
        logic [10:0] kh_max;
        logic [10:0] trunk_lim;
        logic [10:0] leg_lim;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_MAX_W-1:0] x;
        logic signed [COORD_MAX_W-1:0] y;
        logic [15:0]                   conf;
    } joint_t;

    typedef struct packed {
        joint_t [JOINTS-1:0]           joint;
        logic signed [COORD_MAX_W-1:0] bx_min;
        logic signed [COORD_MAX_W-1:0] bx_max;
        logic signed [COORD_MAX_W-1:0] by_min;
        logic signed [COORD_MAX_W-1:0] by_max;
    } job_t;

endpackage
`default_nettype wire

[rtl/pfc_front.sv]
// Front part: takes keypoints, keeps the joints and the box, hands out one job per person.
`timescale 1ns / 1ps
`default_nettype none
module pfc_front import pfc_pkg::*; #(
    parameter int KEYPOINTS       = 17,
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] kp_x,
    input  wire logic [15:0] kp_y,
    input  wire logic [15:0] kp_conf,
    input  wire logic        kp_last,
    input  wire logic        q_full,
    output logic             push,
    output job_t             job
);

    localparam int IW   = $clog2(KEYPOINTS + 1);
    localparam int HALF = (1 << COORD_FRAC_BITS) >> 1;
    localparam logic signed [17:0] CMAX = 18'(32767 >> COORD_FRAC_BITS);
    localparam logic signed [17:0] CMIN = -18'(32768 >> COORD_FRAC_BITS);

    logic          accept;
    logic [IW-1:0] index_reg, index_next;
    joint_t        joint_reg [JOINTS];
    joint_t        joint_next [JOINTS];
    logic signed [COORD_MAX_W-1:0] bx_min_reg, bx_max_reg, by_min_reg, by_max_reg;
    logic signed [COORD_MAX_W-1:0] bx_min_next, bx_max_next, by_min_next, by_max_next;
    logic          slot_hit;
    logic [2:0]    slot;
    logic signed [17:0] vx, vy, tx, ty, rx, ry;

    assign accept = start & ~q_full;
    assign push   = accept & kp_last;

    function automatic logic signed [17:0] trunc_c(input logic signed [17:0] v);
        logic signed [17:0] n;
        n = -v;
        return v[17] ? -(n >>> COORD_FRAC_BITS) : (v >>> COORD_FRAC_BITS);
    endfunction

    function automatic logic signed [17:0] round_c(input logic signed [17:0] v);
        logic signed [17:0] n;
        logic signed [17:0] r;
        n = -v + 18'(HALF);
        r = v[17] ? -(n >>> COORD_FRAC_BITS) : ((v + 18'(HALF)) >>> COORD_FRAC_BITS);
        if (r > CMAX) r = CMAX;
        if (r < CMIN) r = CMIN;
        return r;
    endfunction

    always_comb
    begin
        vx = 18'($signed(kp_x));
        vy = 18'($signed(kp_y));
        tx = trunc_c(vx);
        ty = trunc_c(vy);
        rx = round_c(vx);
        ry = round_c(vy);
    end

    always_comb
    begin
        slot_hit = 1'b1;
        slot     = 3'(SL_SH0);
        unique case (index_reg)
            IW'(KP_L_SHOULDER): slot = 3'(SL_SH0);
            IW'(KP_R_SHOULDER): slot = 3'(SL_SH1);
            IW'(KP_L_HIP):      slot = 3'(SL_HP0);
            IW'(KP_R_HIP):      slot = 3'(SL_HP1);
            IW'(KP_L_KNEE):     slot = 3'(SL_KN0);
            IW'(KP_R_KNEE):     slot = 3'(SL_KN1);
            IW'(KP_L_ANKLE):    slot = 3'(SL_AN0);
            IW'(KP_R_ANKLE):    slot = 3'(SL_AN1);
            default:            slot_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        joint_next  = joint_reg;
        index_next  = index_reg;
        bx_min_next = bx_min_reg;
        bx_max_next = bx_max_reg;
        by_min_next = by_min_reg;
        by_max_next = by_max_reg;
        if (accept && index_reg < IW'(KEYPOINTS))
        begin
            if (slot_hit)
            begin
                joint_next[slot].x    = COORD_MAX_W'(tx);
                joint_next[slot].y    = COORD_MAX_W'(ty);
                joint_next[slot].conf = kp_conf;
            end
            if (kp_conf != 16'd0)
            begin
                if (COORD_MAX_W'(rx) < bx_min_next) bx_min_next = COORD_MAX_W'(rx);
                if (COORD_MAX_W'(rx) > bx_max_next) bx_max_next = COORD_MAX_W'(rx);
                if (COORD_MAX_W'(ry) < by_min_next) by_min_next = COORD_MAX_W'(ry);
                if (COORD_MAX_W'(ry) > by_max_next) by_max_next = COORD_MAX_W'(ry);
            end
            index_next = index_reg + IW'(1);
        end
    end

    always_comb
    begin
        for (int s = 0; s < JOINTS; s++)
        begin
            job.joint[s] = joint_next[s];
        end
        job.bx_min = bx_min_next;
        job.bx_max = bx_max_next;
        job.by_min = by_min_next;
        job.by_max = by_max_next;
    end

    always_ff @(posedge clk)
    begin
        joint_reg <= joint_next;
    end

    // close the person on the last mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            bx_min_reg <= COORD_MAX_W'(CMAX);
            by_min_reg <= COORD_MAX_W'(CMAX);
            bx_max_reg <= COORD_MAX_W'(CMIN);
            by_max_reg <= COORD_MAX_W'(CMIN);
        end
        else if (push)
        begin
            index_reg  <= '0;
            bx_min_reg <= COORD_MAX_W'(CMAX);
            by_min_reg <= COORD_MAX_W'(CMAX);
            bx_max_reg <= COORD_MAX_W'(CMIN);
            by_max_reg <= COORD_MAX_W'(CMIN);
        end
        else
        begin
            index_reg  <= index_next;
            bx_min_reg <= bx_min_next;
            bx_max_reg <= bx_max_next;
            by_min_reg <= by_min_next;
            by_max_reg <= by_max_next;
        end
    end

endmodule
`default_nettype wire

[rtl/pfc_queue.sv]
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module pfc_queue import pfc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      valid,
    output job_t      head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule
`default_nettype wire

[rtl/pfc_cordic.sv]
// Iterative CORDIC vectoring unit: one step a cycle, angle in tenths of a degree.
`timescale 1ns / 1ps
`default_nettype none
module pfc_cordic import pfc_pkg::*; #(
    parameter int PW = 27
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire logic signed [PW-1:0] x0,
    input  wire logic signed [PW-1:0] y0,
    output logic                      done,
    output logic signed [ZW-1:0]      z
);

    localparam int AW = PW + SCALE_SH + 2;
    localparam int NW = $clog2(ANG_STEPS);

    logic signed [AW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg;
    logic [NW-1:0]        cnt_reg;
    logic                 run_reg, done_reg;
    logic signed [ZW-1:0] t;

    assign done = done_reg;
    assign z    = z_reg;
    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign t    = ZW'($signed({1'b0, ATAN_TAB[cnt_reg]}));

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (y0 == '0)
            begin
                z_reg <= x0[PW-1] ? Z_180 : Z_ZERO;
            end
            else if (x0 == '0)
            begin
                z_reg <= Z_90;
            end
            else if (x0[PW-1])
            begin
                // turn by a quarter so the vector starts in the right half plane
                x_reg <= AW'(y0) <<< SCALE_SH;
                y_reg <= -(AW'(x0) <<< SCALE_SH);
                z_reg <= Z_90;
            end
            else
            begin
                x_reg <= AW'(x0) <<< SCALE_SH;
                y_reg <= AW'(y0) <<< SCALE_SH;
                z_reg <= Z_ZERO;
            end
        end
        else if (run_reg)
        begin
            if (!y_reg[AW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= '0;
                if (y0 == '0 || x0 == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                if (cnt_reg == NW'(ANG_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + NW'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pfc_back.sv]
// Back part: tests the five rules for the job at the head of the queue.
`timescale 1ns / 1ps
`default_nettype none
module pfc_back import pfc_pkg::*; #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire job_t  head,
    output logic       pop,
    output logic       done,
    output logic       fall_detected,
    output logic [2:0] fired_rule
);

    localparam int CW = COORD_MAX_W - COORD_FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int MW = 2 * DW;
    localparam int PW = MW + 1;

    back_state_t state_reg, state_next;
    logic [1:0]  ai_reg, ai_next;

    logic signed [CW-1:0] jx [JOINTS];
    logic signed [CW-1:0] jy [JOINTS];
    logic [JOINTS-1:0]    ok;

    logic signed [CW-1:0] chx, chy, csx, csy, ckx, cky, cax, cay, smin, smax, kmin, amid;
    logic signed [CW:0]   bw, bh;
    logic [CW+16:0]       w_sc, h_sc;
    logic                 r1, r2, r3;
    logic signed [DW-1:0] d1x, d1y, d2x, d2y, v1x, v1y, v2x, v2y, v4x, v4y;

    logic r1_reg, r2_reg, r3_reg, en4_reg, en5_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic signed [DW-1:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg, v3x_reg, v3y_reg;
    logic signed [DW-1:0] v4x_reg, v4y_reg;
    logic signed [DW-1:0] ax, ay, bx, by;
    logic signed [MW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [ZW-1:0] z_reg [4];

    logic                 cor_go, cor_done;
    logic signed [PW-1:0] cor_x, cor_y, dot, crs;
    logic signed [ZW-1:0] cor_z, zmn, zmx;

    logic       done_reg, fall_reg;
    logic [2:0] rule_reg;
    rule_t      rule;

    assign done          = done_reg;
    assign fall_detected = fall_reg;
    assign fired_rule    = rule_reg;

    // midpoint, truncated toward zero
    function automatic logic signed [CW-1:0] mid2(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        logic signed [CW:0] u;
        s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
        u = s + $signed({{CW{1'b0}}, s[CW]});
        u = u >>> 1;
        return u[CW-1:0];
    endfunction

    function automatic logic signed [ZW-1:0] lim(input logic [10:0] t);
        return $signed({2'b00, t, 16'h0000});
    endfunction

    always_comb
    begin
        for (int s = 0; s < JOINTS; s++)
        begin
            jx[s] = head.joint[s].x[CW-1:0];
            jy[s] = head.joint[s].y[CW-1:0];
            ok[s] = head.joint[s].conf > cfg.conf_thr;
        end
        chx  = mid2(jx[SL_HP0], jx[SL_HP1]);
        chy  = mid2(jy[SL_HP0], jy[SL_HP1]);
        csx  = mid2(jx[SL_SH0], jx[SL_SH1]);
        csy  = mid2(jy[SL_SH0], jy[SL_SH1]);
        ckx  = mid2(jx[SL_KN0], jx[SL_KN1]);
        cky  = mid2(jy[SL_KN0], jy[SL_KN1]);
        cax  = mid2(jx[SL_AN0], jx[SL_AN1]);
        cay  = mid2(jy[SL_AN0], jy[SL_AN1]);
        amid = cay;
        smin = (jy[SL_SH0] < jy[SL_SH1]) ? jy[SL_SH0] : jy[SL_SH1];
        smax = (jy[SL_SH0] > jy[SL_SH1]) ? jy[SL_SH0] : jy[SL_SH1];
        kmin = (jy[SL_KN0] < jy[SL_KN1]) ? jy[SL_KN0] : jy[SL_KN1];

        r1 = ok[SL_SH0] & ok[SL_SH1] & ok[SL_AN0] & ok[SL_AN1] & (smin >= amid);
        r2 = ok[SL_SH0] & ok[SL_SH1] & ok[SL_KN0] & ok[SL_KN1] & (smax > kmin);

        bw   = $signed({head.bx_max[CW-1], head.bx_max[CW-1:0]})
             - $signed({head.bx_min[CW-1], head.bx_min[CW-1:0]});
        bh   = $signed({head.by_max[CW-1], head.by_max[CW-1:0]})
             - $signed({head.by_min[CW-1], head.by_min[CW-1:0]});
        w_sc = {8'h00, bw[CW:0], 8'h00};
        h_sc = (CW+17)'(cfg.aspect_lim) * (CW+17)'(bh[CW:0]);
        r3   = (bw > 0) & (bh > 0) & (w_sc > h_sc);

        d1x = DW'(jx[SL_KN0]) - DW'(chx);
        d1y = DW'(jy[SL_KN0]) - DW'(chy);
        d2x = DW'(jx[SL_KN1]) - DW'(chx);
        d2y = DW'(jy[SL_KN1]) - DW'(chy);
        v1x = DW'(csx) - DW'(chx);
        v1y = DW'(csy) - DW'(chy);
        v2x = DW'(ckx) - DW'(chx);
        v2y = DW'(cky) - DW'(chy);
        v4x = DW'(cax) - DW'(ckx);
        v4y = DW'(cay) - DW'(cky);
    end

    // CORDIC operands: a knee vector from the hip centre, or products for the angle between two vectors
    always_comb
    begin
        if (ai_reg == 2'd2)
        begin
            ax = v1x_reg;
            ay = v1y_reg;
            bx = v2x_reg;
            by = v2y_reg;
        end
        else
        begin
            ax = v3x_reg;
            ay = v3y_reg;
            bx = v4x_reg;
            by = v4y_reg;
        end
        dot = PW'(p1_reg) + PW'(p2_reg);
        crs = PW'(p3_reg) - PW'(p4_reg);
        case (ai_reg)
            2'd0:
            begin
                cor_x = PW'(d1x_reg);
                cor_y = d1y_reg[DW-1] ? -PW'(d1y_reg) : PW'(d1y_reg);
            end
            2'd1:
            begin
                cor_x = PW'(d2x_reg);
                cor_y = d2y_reg[DW-1] ? -PW'(d2y_reg) : PW'(d2y_reg);
            end
            default:
            begin
                cor_x = dot;
                cor_y = crs[PW-1] ? -crs : crs;
            end
        endcase
    end

    always_comb
    begin
        zmn  = (z_reg[0] < z_reg[1]) ? z_reg[0] : z_reg[1];
        zmx  = (z_reg[0] < z_reg[1]) ? z_reg[1] : z_reg[0];
        rule = RULE_NONE;
        if (r1_reg)
            rule = RULE_ANKLE;
        else if (r2_reg)
            rule = RULE_KNEE;
        else if (r3_reg)
            rule = RULE_ASPECT;
        else if (en4_reg && zmn < lim(cfg.kh_min) && zmx < lim(cfg.kh_max))
            rule = RULE_KNEE_HIP;
        else if (en5_reg && z_reg[2] < lim(cfg.trunk_lim) && z_reg[3] < lim(cfg.leg_lim))
            rule = RULE_TRUNK;
    end

    always_comb
    begin
        state_next = state_reg;
        ai_next    = ai_reg;
        cor_go     = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_PREP;
                end
            end
            BK_PREP:
            begin
                ai_next    = 2'd0;
                state_next = BK_ANG_GO;
            end
            BK_MUL_A:
            begin
                state_next = BK_MUL_B;
            end
            BK_MUL_B:
            begin
                state_next = BK_ANG_GO;
            end
            BK_ANG_GO:
            begin
                cor_go     = 1'b1;
                state_next = BK_ANG_WAIT;
            end
            BK_ANG_WAIT:
            begin
                if (cor_done)
                begin
                    if (ai_reg == 2'd3)
                    begin
                        state_next = BK_DECIDE;
                    end
                    else
                    begin
                        ai_next    = ai_reg + 2'd1;
                        state_next = (ai_reg >= 2'd1) ? BK_MUL_A : BK_ANG_GO;
                    end
                end
            end
            BK_DECIDE:
            begin
                pop        = 1'b1;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_PREP)
        begin
            r1_reg  <= r1;
            r2_reg  <= r2;
            r3_reg  <= r3;
            en4_reg <= ok[SL_KN0] & ok[SL_KN1] & ok[SL_HP0] & ok[SL_HP1]
                     & ((d1x != '0) | (d1y != '0)) & ((d2x != '0) | (d2y != '0));
            en5_reg <= (&ok) & ((v1x != '0) | (v1y != '0))
                     & ((v2x != '0) | (v2y != '0)) & ((v4x != '0) | (v4y != '0));
            d1x_reg <= d1x;
            d1y_reg <= d1y;
            d2x_reg <= d2x;
            d2y_reg <= d2y;
            v1x_reg <= v1x;
            v1y_reg <= v1y;
            v2x_reg <= v2x;
            v2y_reg <= v2y;
            v3x_reg <= -v2x;
            v3y_reg <= -v2y;
            v4x_reg <= v4x;
            v4y_reg <= v4y;
        end
        if (state_reg == BK_MUL_A)
        begin
            p1_reg <= ax * bx;
            p2_reg <= ay * by;
        end
        if (state_reg == BK_MUL_B)
        begin
            p3_reg <= ax * by;
            p4_reg <= ay * bx;
        end
        if (state_reg == BK_ANG_WAIT && cor_done)
        begin
            z_reg[ai_reg] <= cor_z;
        end
        if (state_reg == BK_DECIDE)
        begin
            fall_reg <= rule != RULE_NONE;
            rule_reg <= rule;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ai_reg    <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ai_reg    <= ai_next;
            done_reg  <= state_reg == BK_DECIDE;
        end
    end

    pfc_cordic #(
        .PW (PW)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cor_go),
        .x0    (cor_x),
        .y0    (cor_y),
        .done  (cor_done),
        .z     (cor_z)
    );

endmodule
`default_nettype wire

[rtl/pose_fall_classifier.sv]
// Top level of the pose fall classifier: configuration registers, front, queue and back.
//
//  channel   signals                                    transfer
//  keypoint  start, busy, kp_x, kp_y, kp_conf, kp_last  edge with start high and busy low
//  result    done, fall_detected, fired_rule            edge ending the cycle done is high
//  config    cfg_we, cfg_index, cfg_data                edge with cfg_we high
//
// Keypoints are taken one per cycle while the queue has room.
// With the back part idle, a person's job passes through the back part's states in
// order: PREP, the four angles, each worked out by the CORDIC unit at one step a cycle
// (after MUL_A and MUL_B for the angles between vectors), DECIDE; then done rises.
// The queue holds two persons, the one under evaluation included; busy is high while
// it is full and stalls every keypoint.
// Reset sets control, box and config state; the joint store holds garbage until written.
// The result is shown for one cycle and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module pose_fall_classifier import pfc_pkg::*; #(
    parameter int KEYPOINTS       = 17,
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] kp_x,
    input  wire logic [15:0] kp_y,
    input  wire logic [15:0] kp_conf,
    input  wire logic        kp_last,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic             fall_detected,
    output logic [2:0]       fired_rule
);

    cfg_t cfg_reg;
    logic q_full, q_valid, push, pop;
    job_t push_job, head;

    assign busy = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_thr   <= RST_CONF_THR;
            cfg_reg.aspect_lim <= RST_ASPECT;
            cfg_reg.kh_min     <= RST_KH_MIN;
            cfg_reg.kh_max     <= RST_KH_MAX;
            cfg_reg.trunk_lim  <= RST_TRUNK;
            cfg_reg.leg_lim    <= RST_LEG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONF_THR: cfg_reg.conf_thr   <= cfg_data;
                CFG_ASPECT:   cfg_reg.aspect_lim <= cfg_data;
                CFG_KH_MIN:   cfg_reg.kh_min     <= cfg_data[10:0];
                CFG_KH_MAX:   cfg_reg.kh_max     <= cfg_data[10:0];
                CFG_TRUNK:    cfg_reg.trunk_lim  <= cfg_data[10:0];
                CFG_LEG:      cfg_reg.leg_lim    <= cfg_data[10:0];
                default:      ;
            endcase
        end
    end

    pfc_front #(
        .KEYPOINTS       (KEYPOINTS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kp_x    (kp_x),
        .kp_y    (kp_y),
        .kp_conf (kp_conf),
        .kp_last (kp_last),
        .q_full  (q_full),
        .push    (push),
        .job     (push_job)
    );

    pfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head)
    );

    pfc_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .done          (done),
        .fall_detected (fall_detected),
        .fired_rule    (fired_rule)
    );

endmodule
`default_nettype wire

[rtl/pfc_checker.sv]
// Port checker for the pose fall classifier and its bind.
`timescale 1ns / 1ps
`default_nettype none
module pfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        fall_detected,
    input wire logic [2:0]  fired_rule
);

    // results are spaced by the evaluation, never on adjacent cycles
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on adjacent cycles");

    a_fall_matches_rule: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fall_detected == (fired_rule != 3'd0)))
        else $error("fall flag disagrees with rule");

    a_rule_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fired_rule <= 3'd5))
        else $error("rule out of range");

    // a full queue only frees a place as a result comes out
    a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (busy || done))
        else $error("busy dropped without a result");

endmodule

bind pose_fall_classifier pfc_checker u_pfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .fall_detected (fall_detected),
    .fired_rule    (fired_rule)
);
`default_nettype wire

[verif/tb_pose_fall_classifier.sv]
// Self-checking testbench of the pose fall classifier: scoreboard class and keypoint driver.
`timescale 1ns / 1ps
`default_nettype none
module tb_pose_fall_classifier import pfc_pkg::*; ();

    localparam int NKP = 17;
    localparam int FRAC = 4;
    localparam int PIX_MAX = 32767 >> FRAC;
    localparam int PIX_MIN = -(32768 >> FRAC);

    typedef struct {
        bit    fall;
        rule_t rule;
    } verdict_t;

    class fall_scoreboard;
        int          js_x[8];
        int          js_y[8];
        bit [15:0]   js_c[8];
        int          kp_count;
        int          bx_min, bx_max, by_min, by_max;
        bit [15:0]   conf_thr, aspect_lim;
        bit [10:0]   kh_min, kh_max, trunk_lim, leg_lim;
        verdict_t    verdicts[$];
        int          errors;
        longint      atan_steps[20] = '{
            29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
            146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146, 573, 286, 143, 72};

        function new();
            errors = 0;
            conf_thr = 16'd32768;
            aspect_lim = 16'd256;
            kh_min = 11'd450;
            kh_max = 11'd900;
            trunk_lim = 11'd1200;
            leg_lim = 11'd1200;
            clear_person();
        endfunction

        function void clear_person();
            kp_count = 0;
            bx_min = PIX_MAX;
            by_min = PIX_MAX;
            bx_max = PIX_MIN;
            by_max = PIX_MIN;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(cfg_index_t idx, bit [15:0] val);
            case (idx)
                CFG_CONF_THR: conf_thr = val;
                CFG_ASPECT:   aspect_lim = val;
                CFG_KH_MIN:   kh_min = val[10:0];
                CFG_KH_MAX:   kh_max = val[10:0];
                CFG_TRUNK:    trunk_lim = val[10:0];
                CFG_LEG:      leg_lim = val[10:0];
                default: ;
            endcase
        endfunction

        function int to_pixel(int v);
            return v >= 0 ? (v >>> FRAC) : -((-v) >>> FRAC);
        endfunction

        function int round_pixel(int v);
            int r;
            r = v >= 0 ? ((v + 8) >>> FRAC) : -(((-v) + 8) >>> FRAC);
            if (r > PIX_MAX) r = PIX_MAX;
            if (r < PIX_MIN) r = PIX_MIN;
            return r;
        endfunction

        function int midpoint(int a, int b);
            return (a + b) / 2;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // atan2 for y0 >= 0, tenths of a degree with 16 fraction bits
        function longint bearing(longint x0, longint y0);
            longint x, y, z, xs, ys;
            if (y0 == 0) return x0 >= 0 ? 64'sd0 : 64'sd1800 * 65536;
            if (x0 == 0) return 64'sd900 * 65536;
            if (x0 < 0)
            begin
                x = y0 <<< 20;
                y = (-x0) <<< 20;
                z = 64'sd900 * 65536;
            end
            else
            begin
                x = x0 <<< 20;
                y = y0 <<< 20;
                z = 0;
            end
            for (int i = 0; i < 20; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += atan_steps[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= atan_steps[i];
                end
            end
            return z;
        endfunction

        function rule_t classify();
            bit ok[8];
            int chx, chy, smin, smax, kmin;
            longint w, h, d1x, d1y, d2x, d2y, a1, a2, mn, mx;
            longint v1x, v1y, v2x, v2y, v4x, v4y, t3, t4;
            for (int s = 0; s < 8; s++) ok[s] = js_c[s] > conf_thr;
            chx = midpoint(js_x[2], js_x[3]);
            chy = midpoint(js_y[2], js_y[3]);
            if (ok[0] && ok[1] && ok[6] && ok[7])
            begin
                smin = js_y[0] < js_y[1] ? js_y[0] : js_y[1];
                if (smin >= midpoint(js_y[6], js_y[7])) return RULE_ANKLE;
            end
            if (ok[0] && ok[1] && ok[4] && ok[5])
            begin
                smax = js_y[0] > js_y[1] ? js_y[0] : js_y[1];
                kmin = js_y[4] < js_y[5] ? js_y[4] : js_y[5];
                if (smax > kmin) return RULE_KNEE;
            end
            if (bx_max > bx_min && by_max > by_min)
            begin
                w = bx_max - bx_min;
                h = by_max - by_min;
                if (w * 256 > longint'(aspect_lim) * h) return RULE_ASPECT;
            end
            if (ok[4] && ok[5] && ok[2] && ok[3])
            begin
                d1x = js_x[4] - chx; d1y = js_y[4] - chy;
                d2x = js_x[5] - chx; d2y = js_y[5] - chy;
                if ((d1x != 0 || d1y != 0) && (d2x != 0 || d2y != 0))
                begin
                    a1 = bearing(d1x, mag(d1y));
                    a2 = bearing(d2x, mag(d2y));
                    mn = a1 < a2 ? a1 : a2;
                    mx = a1 < a2 ? a2 : a1;
                    if (mn < longint'(kh_min) * 65536 && mx < longint'(kh_max) * 65536)
                        return RULE_KNEE_HIP;
                end
            end
            if (ok[0] && ok[1] && ok[2] && ok[3] && ok[4] && ok[5] && ok[6] && ok[7])
            begin
                v1x = midpoint(js_x[0], js_x[1]) - chx;
                v1y = midpoint(js_y[0], js_y[1]) - chy;
                v2x = midpoint(js_x[4], js_x[5]) - chx;
                v2y = midpoint(js_y[4], js_y[5]) - chy;
                v4x = midpoint(js_x[6], js_x[7]) - midpoint(js_x[4], js_x[5]);
                v4y = midpoint(js_y[6], js_y[7]) - midpoint(js_y[4], js_y[5]);
                if ((v1x != 0 || v1y != 0) && (v2x != 0 || v2y != 0) &&
                    (v4x != 0 || v4y != 0))
                begin
                    t3 = bearing(v1x * v2x + v1y * v2y, mag(v1x * v2y - v1y * v2x));
                    t4 = bearing(-v2x * v4x - v2y * v4y, mag(-v2x * v4y + v2y * v4x));
                    if (t3 < longint'(trunk_lim) * 65536 && t4 < longint'(leg_lim) * 65536)
                        return RULE_TRUNK;
                end
            end
            return RULE_NONE;
        endfunction

        function void note_keypoint(bit [15:0] x, bit [15:0] y, bit [15:0] c, bit last);
            int sx, sy, slot, rx, ry;
            verdict_t v;
            sx = int'($signed(x));
            sy = int'($signed(y));
            if (kp_count < NKP)
            begin
                case (kp_count)
                    KP_L_SHOULDER: slot = SL_SH0;
                    KP_R_SHOULDER: slot = SL_SH1;
                    KP_L_HIP:      slot = SL_HP0;
                    KP_R_HIP:      slot = SL_HP1;
                    KP_L_KNEE:     slot = SL_KN0;
                    KP_R_KNEE:     slot = SL_KN1;
                    KP_L_ANKLE:    slot = SL_AN0;
                    KP_R_ANKLE:    slot = SL_AN1;
                    default:       slot = -1;
                endcase
                if (slot >= 0)
                begin
                    js_x[slot] = to_pixel(sx);
                    js_y[slot] = to_pixel(sy);
                    js_c[slot] = c;
                end
                if (c > 0)
                begin
                    rx = round_pixel(sx);
                    ry = round_pixel(sy);
                    if (rx < bx_min) bx_min = rx;
                    if (rx > bx_max) bx_max = rx;
                    if (ry < by_min) by_min = ry;
                    if (ry > by_max) by_max = ry;
                end
                kp_count++;
            end
            if (last)
            begin
                v.rule = classify();
                v.fall = v.rule != RULE_NONE;
                verdicts.insert(verdicts.size(), v);
                clear_person();
            end
        endfunction

        task check_verdict(bit fall, bit [2:0] rule);
            verdict_t v;
            if (verdicts.size() == 0)
            begin
                report($sformatf("unexpected result fall=%0d rule=%0d", fall, rule));
                return;
            end
            v = verdicts.pop_front();
            if (fall !== v.fall)
                report($sformatf("fall_detected %0d, expected %0d", fall, v.fall));
            if (rule !== v.rule)
                report($sformatf("fired_rule %0d, expected %0d", rule, v.rule));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] kp_x, kp_y, kp_conf;
    logic        kp_last;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic        fall_detected;
    logic [2:0]  fired_rule;

    fall_scoreboard sb;
    int             pose_x[8], pose_y[8];

    pose_fall_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kp_x          (kp_x),
        .kp_y          (kp_y),
        .kp_conf       (kp_conf),
        .kp_last       (kp_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .fall_detected (fall_detected),
        .fired_rule    (fired_rule)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("tb_pose_fall_classifier: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_verdict(fall_detected, fired_rule);
    end

    // Hold start high across back-to-back transfers; drop it only for a gap.
    task send_keypoint(bit [15:0] x, bit [15:0] y, bit [15:0] c, bit last, int gap);
        start <= 1'b1;
        kp_x <= x;
        kp_y <= y;
        kp_conf <= c;
        kp_last <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_keypoint(x, y, c, last);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Leave the write enable high; the caller drops it after the last write.
    task write_reg(cfg_index_t idx, bit [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task drain();
        while (sb.verdicts.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function bit [15:0] to_q(int pix);
        int q;
        q = pix * 16 + $urandom_range(0, 15) - 8;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function bit [15:0] pick_conf();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(40000, 65535));
        if (r < 92) return 16'($urandom_range(0, 65535));
        return 16'd0;
    endfunction

    // Build the eight joints of a pose in pixels: standing, lying, bent, folded or random.
    function void shape_pose(int scene);
        int bx, by, jit, t, dx[8], dy[8];
        bit swap_xy, flip_y;
        bx = $urandom_range(0, 1200) - 600;
        by = $urandom_range(0, 1200) - 600;
        jit = $urandom_range(0, 30);
        dx = '{-20, 20, -15, 15, -15, 15, -15, 15};
        dy = '{-100, -100, 0, 0, 60, 60, 120, 120};
        case (scene)
            1: dy = '{-100, -100, 0, 0, 10, 10, 70, 70};
            2: dx = '{-20, 20, -15, 15, 45, 75, 45, 75};
            3: for (int j = 0; j < 8; j++)
            begin
                dx[j] = $urandom_range(0, 300) - 150;
                dy[j] = $urandom_range(0, 300) - 150;
            end
            4: for (int j = 0; j < 8; j++)
            begin
                dx[j] = 0;
                dy[j] = 0;
            end
            default: ;
        endcase
        swap_xy = $urandom_range(0, 3) == 0;
        flip_y = $urandom_range(0, 5) == 0;
        for (int j = 0; j < 8; j++)
        begin
            if (scene != 4)
            begin
                dx[j] += $urandom_range(0, 2 * jit) - jit;
                dy[j] += $urandom_range(0, 2 * jit) - jit;
            end
            if (flip_y) dy[j] = -dy[j];
            if (swap_xy)
            begin
                t = dx[j]; dx[j] = dy[j]; dy[j] = t;
            end
            pose_x[j] = bx + dx[j];
            pose_y[j] = by + dy[j];
        end
    endfunction

    function int joint_of(int k);
        case (k)
            KP_L_SHOULDER: return SL_SH0;
            KP_R_SHOULDER: return SL_SH1;
            KP_L_HIP:      return SL_HP0;
            KP_R_HIP:      return SL_HP1;
            KP_L_KNEE:     return SL_KN0;
            KP_R_KNEE:     return SL_KN1;
            KP_L_ANKLE:    return SL_AN0;
            KP_R_ANKLE:    return SL_AN1;
            default:       return -1;
        endcase
    endfunction

    task send_person(int n_items, bit idle);
        int j, gap;
        bit [15:0] x, y;
        shape_pose($urandom_range(0, 5));
        for (int k = 0; k < n_items; k++)
        begin
            j = k < NKP ? joint_of(k) : -1;
            if ($urandom_range(0, 19) == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else if (j >= 0)
            begin
                x = to_q(pose_x[j]);
                y = to_q(pose_y[j]);
            end
            else
            begin
                x = to_q(pose_x[SL_HP0] + $urandom_range(0, 160) - 80);
                y = to_q(pose_y[SL_HP0] + $urandom_range(0, 160) - 80);
            end
            gap = idle ? $urandom_range(0, 9) : 0;
            send_keypoint(x, y, pick_conf(), k == n_items - 1, gap);
        end
    endtask

    initial
    begin
        bit [15:0] settings[5][6];
        int        n;
        sb = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        kp_x <= '0;
        kp_y <= '0;
        kp_conf <= '0;
        kp_last <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_CONF_THR;
        cfg_data <= '0;
        settings[0] = '{16'd0, 16'd0, 16'd1800, 16'd1800, 16'd0, 16'd0};
        settings[1] = '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1800, 16'd1800};
        settings[2] = '{16'd50000, 16'd128, 16'd2047, 16'd2047, 16'd2047, 16'd2047};
        settings[3] = '{16'd20000, 16'd512, 16'd600, 16'd1200, 16'd1500, 16'd1500};
        settings[4] = '{16'($urandom), 16'($urandom), 16'($urandom_range(0, 1800)),
                        16'($urandom_range(0, 1800)), 16'($urandom_range(0, 1800)),
                        16'($urandom_range(0, 1800))};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme coordinates and confidences; the first person fills every joint.
        for (int k = 0; k < NKP; k++)
        begin
            case (k)
                0: send_keypoint(16'h8000, 16'h7fff, 16'hffff, 1'b0, 0);
                1: send_keypoint(16'h7fff, 16'h8000, 16'd1, 1'b0, 1);
                2: send_keypoint(16'h7ff9, 16'h0000, 16'd0, 1'b0, 0);
                3: send_keypoint(16'hfff8, 16'h0008, 16'd32768, 1'b0, 0);
                4: send_keypoint(16'h0007, 16'hfff9, 16'd32769, 1'b0, 2);
                default: send_keypoint(to_q(k * 7), to_q(k * 11 - 90),
                                       16'hffff, k == NKP - 1, 0);
            endcase
        end
        // Early last mark: the joints stay as the previous person left them.
        send_keypoint(16'h0100, 16'h0200, 16'd500, 1'b0, 0);
        send_keypoint(16'hff00, 16'h0100, 16'd0, 1'b1, 0);
        send_keypoint(16'h0000, 16'h0000, 16'd0, 1'b1, 3);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                for (int r = 0; r < 6; r++)
                    write_reg(cfg_index_t'(r), settings[phase - 1][r]);
                cfg_we <= 1'b0;
            end
            for (int p = 0; p < 8; p++)
            begin
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(1, NKP - 1);
                    1: n = $urandom_range(NKP + 1, NKP + 5);
                    default: n = NKP;
                endcase
                send_person(n, $urandom_range(0, 2) != 0);
            end
            start <= 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("tb_pose_fall_classifier: done, clean");
        else
            $display("tb_pose_fall_classifier: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
